// ----- hw/rtl/bbx_pkg.sv -----
// Shared constants, types and the reciprocal table for the 3x3 box blur.
// No dependencies; used by bbx_ram and box_blur_3x3.
package bbx_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int LINE_W      = 2 * PIX_W;
   localparam int SUM_W       = 12;
   localparam int NUM_W       = SUM_W + 1;
   localparam int CNT_W       = 4;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 20;
   localparam int PROD_W      = NUM_W + RECIP_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_MUL
   } state_type;

   // ceil(2^20 / (2*count)); exact floor division for numerators below 4600
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 20'd524288;
         4'd2:    r = 20'd262144;
         4'd3:    r = 20'd174763;
         4'd4:    r = 20'd131072;
         4'd6:    r = 20'd87382;
         4'd9:    r = 20'd58255;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/bbx_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// Depends on bbx_pkg for default sizes.
module bbx_ram #(
   parameter int WIDTH = bbx_pkg::LINE_W,
   parameter int DEPTH = bbx_pkg::MAX_WIDTH_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/box_blur_3x3.sv -----
// Edge-normalized 3x3 box blur on a raster RGB stream; depends on bbx_pkg, bbx_ram.
// Sequencer per transfer: accept+RAM read, line write-back+window shift, sum, scale.
// A new transfer is taken only in idle: one with no result returns after write-back,
// an ignored drain never leaves idle, and a result waits in scale while a held one
// waits for rsp_tready. The result register is loaded in scale, after read and sum;
// a pixel's result comes out width+1 transfers later. Sync reset: counters zero,
// 640x480, line RAM not cleared (unwritten entries never reach a result).
module box_blur_3x3 #(
   parameter int MAX_WIDTH  = bbx_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbx_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bbx_pkg::PIX_W-1:0]        req_tdata,  // in_red, in_green, in_blue
   input  logic                             req_tuser,  // cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bbx_pkg::PIX_W-1:0]        rsp_tdata,  // out_red, out_green, out_blue
   output logic                             rsp_tlast,  // frame_last
   input  logic                             csr_we,
   input  logic [bbx_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bbx_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int CH     = bbx_pkg::CHAN_W;

   bbx_pkg::state_type state_ff, state_in;

   logic [bbx_pkg::WIDTH_REG_W-1:0]  width_reg_ff;
   logic [bbx_pkg::HEIGHT_REG_W-1:0] height_reg_ff;
   logic [COL_W-1:0] eff_w;
   logic [ROW_W-1:0] eff_h;

   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic [bbx_pkg::PIX_W-1:0] pix_ff, pix_in;
   logic [ADDR_W-1:0]         col_ff, col_in;
   logic                      emit_ff, emit_in;
   logic [bbx_pkg::PIX_W-1:0] win_ff [9];

   logic [bbx_pkg::NUM_W-1:0]   num_ff [3], num_in [3];
   logic [bbx_pkg::RECIP_W-1:0] recip_ff, recip_in;
   logic                        last_ff, last_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bbx_pkg::PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      accept, frame_in, ram_we;
   logic [bbx_pkg::LINE_W-1:0] ram_q;
   logic [bbx_pkg::PIX_W-1:0]  top_pix, mid_pix;
   logic [2:0]                 row_ok, col_ok;
   logic [1:0]                 n_rows, n_cols;
   logic [bbx_pkg::CNT_W-1:0]  count;
   logic [bbx_pkg::SUM_W-1:0]  sums [3];
   logic [bbx_pkg::PROD_W-1:0] prod [3];

   always_comb begin
      if (width_reg_ff == '0) begin
         eff_w = COL_W'(1);
      end else if (32'(width_reg_ff) > MAX_WIDTH) begin
         eff_w = COL_W'(MAX_WIDTH);
      end else begin
         eff_w = COL_W'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (32'(height_reg_ff) > MAX_HEIGHT) begin
         eff_h = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = ROW_W'(height_reg_ff);
      end
   end

   bbx_ram #(
      .WIDTH (bbx_pkg::LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata ({mid_pix, pix_ff}),
      .raddr (in_col_ff[ADDR_W-1:0]),
      .rdata (ram_q)
   );

   // entry layout: upper line high, middle line low
   assign top_pix  = ram_q[bbx_pkg::LINE_W-1:bbx_pkg::PIX_W];
   assign mid_pix  = ram_q[bbx_pkg::PIX_W-1:0];
   assign frame_in = in_row_ff >= eff_h;
   assign accept   = req_tvalid && req_tready;

   // clipped neighborhood
   always_comb begin
      row_ok = {out_row_ff < eff_h - ROW_W'(1), 1'b1, out_row_ff != '0};
      col_ok = {out_col_ff < eff_w - COL_W'(1), 1'b1, out_col_ff != '0};
      n_rows = 2'd1 + 2'(row_ok[0]) + 2'(row_ok[2]);
      n_cols = 2'd1 + 2'(col_ok[0]) + 2'(col_ok[2]);
      count  = bbx_pkg::CNT_W'(n_rows) * bbx_pkg::CNT_W'(n_cols);
      for (int c = 0; c < 3; c++) begin
         sums[c] = '0;
      end
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            if (row_ok[k] && col_ok[m]) begin
               for (int c = 0; c < 3; c++) begin
                  sums[c] = sums[c] + bbx_pkg::SUM_W'(win_ff[k*3+m][(2-c)*CH +: CH]);
               end
            end
         end
      end
      for (int c = 0; c < 3; c++) begin
         prod[c] = bbx_pkg::PROD_W'(num_ff[c]) * bbx_pkg::PROD_W'(recip_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      pix_in       = pix_ff;
      col_in       = col_ff;
      emit_in      = emit_ff;
      recip_in     = recip_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      for (int c = 0; c < 3; c++) begin
         num_in[c] = num_ff[c];
      end
      unique case (state_ff)
         bbx_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && !(req_tuser && !frame_in)) begin
               pix_in  = frame_in ? '0 : {req_tdata[CH-1:0], req_tdata[2*CH-1:CH],
                                          req_tdata[3*CH-1:2*CH]};
               col_in  = in_col_ff[ADDR_W-1:0];
               emit_in = (in_row_ff >= ROW_W'(2))
                         || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
               if (in_col_ff == eff_w - COL_W'(1)) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + ROW_W'(1);
               end else begin
                  in_col_in = in_col_ff + COL_W'(1);
               end
               state_in = bbx_pkg::ST_READ;
            end
         end
         bbx_pkg::ST_READ: begin
            ram_we   = 1'b1;
            state_in = emit_ff ? bbx_pkg::ST_SUM : bbx_pkg::ST_IDLE;
         end
         bbx_pkg::ST_SUM: begin
            for (int c = 0; c < 3; c++) begin
               num_in[c] = {sums[c], 1'b0} + bbx_pkg::NUM_W'(count);
            end
            recip_in = bbx_pkg::recip(count);
            last_in  = (out_row_ff == eff_h - ROW_W'(1)) && (out_col_ff == eff_w - COL_W'(1));
            if (last_in) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff == eff_w - COL_W'(1)) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
            state_in = bbx_pkg::ST_MUL;
         end
         bbx_pkg::ST_MUL: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               for (int c = 0; c < 3; c++) begin
                  rsp_data_in[c*CH +: CH] =
                     prod[c][bbx_pkg::RECIP_SHIFT +: CH];
               end
               state_in = bbx_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      col_ff      <= col_in;
      emit_ff     <= emit_in;
      recip_ff    <= recip_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      for (int c = 0; c < 3; c++) begin
         num_ff[c] <= num_in[c];
      end
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         width_reg_ff  <= bbx_pkg::WIDTH_RESET;
         height_reg_ff <= bbx_pkg::HEIGHT_RESET;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k*3]   <= win_ff[k*3+1];
               win_ff[k*3+1] <= win_ff[k*3+2];
            end
            win_ff[2] <= top_pix;
            win_ff[5] <= mid_pix;
            win_ff[8] <= pix_ff;
         end
         if (csr_we) begin
            unique case (bbx_pkg::csr_reg_type'(csr_index))
               bbx_pkg::REG_IMAGE_WIDTH: begin
                  width_reg_ff <= csr_wdata[bbx_pkg::WIDTH_REG_W-1:0];
               end
               bbx_pkg::REG_IMAGE_HEIGHT: begin
                  height_reg_ff <= csr_wdata[bbx_pkg::HEIGHT_REG_W-1:0];
               end
            endcase
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- tb/box_blur_3x3_tb.sv -----
// Self-checking testbench for box_blur_3x3: a queue-fed stream driver, a monitor with its
// own 3x3 edge-normalized blur predictor, and random idle/stall phases.
// Depends on bbx_pkg and the box_blur_3x3 RTL only.
module box_blur_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE       = 12;
   localparam int STALL_BURST  = 300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 170;

   typedef struct packed {
      logic [bbx_pkg::CHAN_W-1:0] blue;
      logic [bbx_pkg::CHAN_W-1:0] green;
      logic [bbx_pkg::CHAN_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic    cmd;
      rgb_type pix;
   } pixel_item_type;

   typedef struct packed {
      logic    last;
      rgb_type pix;
   } blur_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bbx_pkg::PIX_W-1:0]       req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bbx_pkg::PIX_W-1:0]       rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we     = 1'b0;
   logic [bbx_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [bbx_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   box_blur_3x3 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // in_red, in_green, in_blue
      .req_tuser  (req_tuser),   // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_red, out_green, out_blue
      .rsp_tlast  (rsp_tlast),   // frame_last
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   pixel_item_type  pixel_queue[$];
   blur_result_type blur_expect_q[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int input_transfers = 0;
   int results_checked = 0;
   int items_queued    = 0;
   int cur_width_val   = 640;
   int cur_height_val  = 480;

   // blur predictor state
   logic [10:0] width_reg  = bbx_pkg::WIDTH_RESET;
   logic [12:0] height_reg = bbx_pkg::HEIGHT_RESET;
   rgb_type     upper_mem[bbx_pkg::MAX_WIDTH_DEF];
   rgb_type     middle_mem[bbx_pkg::MAX_WIDTH_DEF];
   rgb_type     window[3][3];
   int          in_col, in_row, out_col, out_row;

   initial begin
      for (int i = 0; i < bbx_pkg::MAX_WIDTH_DEF; i++) begin
         upper_mem[i]  = '0;
         middle_mem[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            window[r][c] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   end

   function automatic int dim_eff(input int v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic bit blur_predict(input pixel_item_type item,
                                       output blur_result_type res);
      int      w, h, col, cnt, sr, sg, sb;
      rgb_type top, mid, cur, p;
      bit      emit;
      w   = dim_eff(int'(width_reg), bbx_pkg::MAX_WIDTH_DEF);
      h   = dim_eff(int'(height_reg), bbx_pkg::MAX_HEIGHT_DEF);
      res = '0;
      if (item.cmd && in_row < h) return 0;   // drain inside a frame is ignored
      cur = (in_row >= h) ? rgb_type'(0) : item.pix;
      col = (in_col < bbx_pkg::MAX_WIDTH_DEF) ? in_col : 0;
      top = upper_mem[col];
      mid = middle_mem[col];
      upper_mem[col]  = mid;
      middle_mem[col] = cur;
      for (int r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = cur;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return 0;
      cnt = 0;
      sr  = 0;
      sg  = 0;
      sb  = 0;
      for (int r = 0; r < 3; r++) begin
         if (r == 0 && out_row == 0) continue;
         if (out_row + r - 1 >= h) continue;
         for (int c = 0; c < 3; c++) begin
            if (c == 0 && out_col == 0) continue;
            if (out_col + c - 1 >= w) continue;
            p = window[r][c];
            sr += p.red;
            sg += p.green;
            sb += p.blue;
            cnt++;
         end
      end
      res.pix.red   = bbx_pkg::CHAN_W'((2 * sr + cnt) / (2 * cnt));
      res.pix.green = bbx_pkg::CHAN_W'((2 * sg + cnt) / (2 * cnt));
      res.pix.blue  = bbx_pkg::CHAN_W'((2 * sb + cnt) / (2 * cnt));
      res.last      = (out_row == h - 1) && (out_col == w - 1);
      if (res.last) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1;
   endfunction

   // stream driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tuser  <= pixel_queue[0].cmd;
            req_tdata  <= pixel_queue[0].pix;
            req_tvalid <= 1'b1;
            void'(pixel_queue.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= STALL_BURST;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      blur_result_type want, got;
      pixel_item_type  seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.cmd = req_tuser;
            seen.pix = req_tdata;
            input_transfers++;
            if (blur_predict(seen, want)) blur_expect_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pix  = rsp_tdata;
            got.last = rsp_tlast;
            results_checked++;
            if (blur_expect_q.size() == 0) begin
               $error("unexpected result transfer: red %0d green %0d blue %0d last %0b",
                      got.pix.red, got.pix.green, got.pix.blue, got.last);
               error_count++;
            end else begin
               want = blur_expect_q.pop_front();
               if (got.pix.red !== want.pix.red) begin
                  $error("out_red: expected %0d, got %0d", want.pix.red, got.pix.red);
                  error_count++;
               end
               if (got.pix.green !== want.pix.green) begin
                  $error("out_green: expected %0d, got %0d", want.pix.green, got.pix.green);
                  error_count++;
               end
               if (got.pix.blue !== want.pix.blue) begin
                  $error("out_blue: expected %0d, got %0d", want.pix.blue, got.pix.blue);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("frame_last: expected %0b, got %0b", want.last, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, blur_expect_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_tvalid || blur_expect_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input bbx_pkg::csr_reg_type idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[bbx_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bbx_pkg::REG_IMAGE_WIDTH) begin
         width_reg     = value[10:0];
         cur_width_val = int'(width_reg);
      end else begin
         height_reg     = value[12:0];
         cur_height_val = int'(height_reg);
      end
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endtask

   task automatic set_dims(input int w_val, input int h_val);
      wait_idle();
      write_reg(bbx_pkg::REG_IMAGE_WIDTH, w_val);
      write_reg(bbx_pkg::REG_IMAGE_HEIGHT, h_val);
   endtask

   task automatic push_item(input logic cmd, input logic [bbx_pkg::PIX_W-1:0] pix);
      pixel_item_type it;
      it.cmd = cmd;
      it.pix = pix;
      pixel_queue.push_back(it);
      if (!cmd) items_queued++;
   endtask

   // npix pixels with the odd ignored drain; a full frame also gets its width+1 drains
   task automatic queue_frame(input int npix, input bit with_noise);
      int w, h;
      w = dim_eff(cur_width_val, bbx_pkg::MAX_WIDTH_DEF);
      h = dim_eff(cur_height_val, bbx_pkg::MAX_HEIGHT_DEF);
      for (int i = 0; i < npix; i++) begin
         if (with_noise && $urandom_range(99) < 4) begin
            push_item(1'b1, bbx_pkg::PIX_W'($urandom()));
         end
         push_item(1'b0, bbx_pkg::PIX_W'($urandom()));
      end
      if (npix == w * h) begin
         for (int i = 0; i <= w; i++) begin
            push_item(1'b1, bbx_pkg::PIX_W'($urandom()));
            if (pixel_queue[$].cmd && $urandom_range(3) == 0) pixel_queue[$].cmd = 1'b0;
            else items_queued++;
         end
      end
   endtask

   task automatic random_traffic(input int target);
      int  start, w, h;
      bit  restart_due;
      start       = items_queued;
      restart_due = 1'b1;
      while (items_queued - start < target) begin
         if (restart_due || $urandom_range(99) < 70) begin
            if ($urandom_range(9) == 0) set_dims($urandom_range(9, 40), $urandom_range(0, 3));
            else set_dims($urandom_range(0, 8), $urandom_range(0, 6));
         end
         w = dim_eff(cur_width_val, bbx_pkg::MAX_WIDTH_DEF);
         h = dim_eff(cur_height_val, bbx_pkg::MAX_HEIGHT_DEF);
         if (w * h > 1 && $urandom_range(99) < 15) begin
            queue_frame($urandom_range(1, w * h - 1), 1'b1);
            restart_due = 1'b1;
         end else begin
            queue_frame(w * h, 1'b1);
            restart_due = 1'b0;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: 3x2 frame with channel extremes, a drain inside the frame,
      // a pixel item after frame end
      set_dims(3, 2);
      push_item(1'b0, 24'hFFFFFF);
      push_item(1'b0, 24'h000000);
      push_item(1'b1, 24'h123456);
      push_item(1'b0, 24'h8000FF);
      push_item(1'b0, 24'h7FFE01);
      push_item(1'b0, 24'hFFFFFF);
      push_item(1'b0, 24'h000000);
      push_item(1'b1, 24'h000000);
      push_item(1'b0, 24'hABCDEF);
      push_item(1'b1, 24'hFFFFFF);
      push_item(1'b1, 24'h000000);
      // partial frame, then a register write mid-frame restarts it
      for (int i = 0; i < 5; i++) push_item(1'b0, bbx_pkg::PIX_W'($urandom()));
      wait_idle();
      write_reg(bbx_pkg::REG_IMAGE_HEIGHT, 1);
      for (int i = 0; i < 3; i++) push_item(1'b0, {3{8'hFF}});
      for (int i = 0; i < 4; i++) push_item(1'b1, 24'h000000);

      // receiver holds off while the sender keeps offering
      set_dims(8, 6);
      hold_requests++;
      queue_frame(48, 1'b0);

      // register extremes on partial frames: width 2047 clamps to 1024 with a zero
      // height, then a zero width with height 8191 clamped to 4096
      set_dims(2047, 0);
      queue_frame(20, 1'b0);
      set_dims(0, 8191);
      queue_frame(30, 1'b0);
      set_dims(1, 1);
      queue_frame(1, 1'b0);

      random_traffic(PHASE_ITEMS);
      wait_idle();
      send_idle_pct = 68;
      random_traffic(PHASE_ITEMS);
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 68;
      random_traffic(PHASE_ITEMS);
      wait_idle();
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      random_traffic(PHASE_ITEMS);
      wait_idle();

      $display("%0d input transfers, %0d blurred pixels checked; frames 1x1 to 40 wide,",
               input_transfers, results_checked);
      $display("clamped sizes, mid-frame restarts, stray drains and receiver back-pressure.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/bbx_pkg.sv
hw/rtl/bbx_ram.sv
hw/rtl/box_blur_3x3.sv
tb/box_blur_3x3_tb.sv
